### hdl/b64enc_pkg.sv
`default_nettype none

package b64enc_pkg;

    // ASCII code of the padding character '='.
    localparam logic [7:0] PAD_CHAR = 8'd61;

    // Number of characters produced for one group of three bytes.
    localparam int unsigned CHARS_PER_GROUP = 4;

    // One group of up to three bytes, handed from the front end to the serialiser.
    typedef struct packed {
        logic [23:0] bits;      // first byte in the top eight bits, missing bytes zero
        logic [1:0]  total;     // number of real bytes in the group, 1 to 3
        logic        last;      // group closes the message
    } b64_group_t;

    // Standard base64 alphabet: A-Z, a-z, 0-9, '+', '/'.
    function automatic logic [7:0] b64_char(input logic [5:0] sextet);
        logic [7:0] code;
        code = {2'b00, sextet};
        if (sextet < 6'd26) begin
            b64_char = code + 8'd65;
        end else if (sextet < 6'd52) begin
            b64_char = code + 8'd71;
        end else if (sextet < 6'd62) begin
            b64_char = code - 8'd4;
        end else if (sextet == 6'd62) begin
            b64_char = 8'd43;
        end else begin
            b64_char = 8'd47;
        end
    endfunction

endpackage

`default_nettype wire

### hdl/base64_stream_encoder.sv
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_ready   data_byte[7:0], end_of_data
// output    out        out_valid / out_ready text_char[7:0], last_char
//
// The front end takes one byte per cycle while the group queue has room.
// Each closed group yields four characters, one per cycle while the output is not
// stalled, so a short closing group yields as many characters as a full one;
// the single-character output port sets the sustained rate. The first character
// of a group passes from the queue through the serialiser's group register to the
// registered output before it is presented.
// Reset clears the pending group, the queue and the output stage at once.
// A stall on the output fills the queue and only then drops in_ready.
`default_nettype none

module base64_stream_encoder
    import b64enc_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic [7:0]      text_char,
    output logic            last_char,
    output logic            out_valid,
    input  wire logic       out_ready
);

    // Closed groups travel from the front end, through the queue, to the
    // serialiser. Each side stalls only on its own neighbour.
    logic       push_valid;
    logic       push_ready;
    b64_group_t push_data;
    logic       pop_valid;
    logic       pop_ready;
    b64_group_t pop_data;

    // The front end holds up to two bytes and closes a group on the third byte
    // or on the byte flagged as the end of the message.
    b64enc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .data_byte   (data_byte),
        .end_of_data (end_of_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .push_valid  (push_valid),
        .push_data   (push_data),
        .push_ready  (push_ready)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    // The serialiser walks the four sextets of a group, substitutes padding for
    // sextets beyond the real bytes, and marks the final character of a message.
    b64enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .text_char (text_char),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

`default_nettype wire

### hdl/b64enc_front.sv
`default_nettype none

// Gathers bytes into groups of three and pushes each closed group into the queue.
module b64enc_front
    import b64enc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [7:0] data_byte,
    input  wire logic       end_of_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            push_valid,
    output b64_group_t      push_data,
    input  wire logic       push_ready
);

    logic [15:0] pending_bytes_reg, pending_bytes_next;
    logic [1:0]  pending_count_reg, pending_count_next;
    logic [1:0]  held;
    logic        closes;
    logic        accept;

    // A count of three never arises; it is treated as two.
    assign held   = (pending_count_reg == 2'd3) ? 2'd2 : pending_count_reg;
    assign closes = end_of_data || (held == 2'd2);

    assign in_ready   = push_ready;
    assign accept     = in_valid && in_ready;
    assign push_valid = accept && closes;

    always_comb
    begin
        push_data.total = held + 2'd1;
        push_data.last  = end_of_data;
        case (held)
            2'd0:    push_data.bits = {data_byte, 16'h0000};
            2'd1:    push_data.bits = {pending_bytes_reg[15:8], data_byte, 8'h00};
            default: push_data.bits = {pending_bytes_reg, data_byte};
        endcase
    end

    always_comb
    begin
        pending_bytes_next = pending_bytes_reg;
        pending_count_next = pending_count_reg;
        if (accept) begin
            if (closes) begin
                pending_bytes_next = 16'h0000;
                pending_count_next = 2'd0;
            end else begin
                if (held == 2'd0) begin
                    pending_bytes_next = {data_byte, 8'h00};
                end else begin
                    pending_bytes_next = {pending_bytes_reg[15:8], data_byte};
                end
                pending_count_next = held + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_bytes_reg <= 16'h0000;
            pending_count_reg <= 2'd0;
        end else begin
            pending_bytes_reg <= pending_bytes_next;
            pending_count_reg <= pending_count_next;
        end
    end

endmodule

`default_nettype wire

### hdl/b64enc_queue.sv
`default_nettype none

// Short first-in first-out queue of closed groups between front end and serialiser.
module b64enc_queue
    import b64enc_pkg::*;
#(
    parameter int unsigned DEPTH = 2
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    input  wire b64_group_t push_data,
    output logic            push_ready,
    output logic            pop_valid,
    output b64_group_t      pop_data,
    input  wire logic       pop_ready
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64_group_t       entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### hdl/b64enc_back.sv
`default_nettype none

// Turns one group into four characters, one per cycle while the output is not stalled, through a registered output.
module b64enc_back
    import b64enc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       pop_valid,
    input  wire b64_group_t pop_data,
    output logic            pop_ready,
    output logic [7:0]      text_char,
    output logic            last_char,
    output logic            out_valid,
    input  wire logic       out_ready
);

    localparam logic [1:0] FINAL_IDX = 2'(CHARS_PER_GROUP - 1);

    b64_group_t  group_reg, group_next;
    logic        busy_reg, busy_next;
    logic [1:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  text_char_reg, text_char_next;
    logic        last_char_reg, last_char_next;
    logic        slot_free;
    logic        emit;
    logic        group_done;
    logic [5:0]  sextet;
    logic        is_pad;

    assign slot_free  = !out_valid_reg || out_ready;
    assign emit       = busy_reg && slot_free;
    assign group_done = emit && (idx_reg == FINAL_IDX);
    assign pop_ready  = !busy_reg || group_done;

    always_comb
    begin
        case (idx_reg)
            2'd0:    sextet = group_reg.bits[23:18];
            2'd1:    sextet = group_reg.bits[17:12];
            2'd2:    sextet = group_reg.bits[11:6];
            default: sextet = group_reg.bits[5:0];
        endcase
        is_pad = ((idx_reg == 2'd2) && (group_reg.total < 2'd2))
              || ((idx_reg == 2'd3) && (group_reg.total < 2'd3));
    end

    always_comb
    begin
        group_next     = group_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        text_char_next = text_char_reg;
        last_char_next = last_char_reg;

        if (out_valid_reg && out_ready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
            text_char_next = is_pad ? PAD_CHAR : b64_char(sextet);
            last_char_next = group_reg.last && (idx_reg == FINAL_IDX);
            idx_next       = idx_reg + 2'd1;
            if (group_done) begin
                busy_next = 1'b0;
            end
        end
        if (pop_valid && pop_ready) begin
            group_next = pop_data;
            busy_next  = 1'b1;
            idx_next   = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        group_reg     <= group_next;
        text_char_reg <= text_char_next;
        last_char_reg <= last_char_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign text_char = text_char_reg;
    assign last_char = last_char_reg;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire
